>>> rtl/pid_position_controller_defines.svh
// ----------------------------------------------------------------------------
// pid position controller assertion macros
// shared property wrappers, clocked on clk and masked while in reset
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_CONTROLLER_DEFINES_SVH
`define PID_POSITION_CONTROLLER_DEFINES_SVH

// plain property, checked at every rising edge outside reset
`define PIDPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// overlapping implication
`define PIDPC_ASSERT_IMP(lbl, ante, cons, msg) \
    `PIDPC_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define PIDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    `PIDPC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> rtl/pidpc_pkg.sv
// ----------------------------------------------------------------------------
// pid position controller package
// widths, register indexes, reset values and defaults shared by the rtl
// ----------------------------------------------------------------------------
`default_nettype none

package pidpc_pkg;

    // default parameter values
    localparam int COUNTER_WIDTH_DEF  = 16;
    localparam int GAIN_FRAC_BITS_DEF = 24;

    // fixed field widths
    localparam int POS_W     = 32;
    localparam int GAIN_W    = 32;
    localparam int LIM_W     = 15;
    localparam int DRIVE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // datapath widths
    localparam int DERR_W = POS_W + 1;
    localparam int PROD_W = GAIN_W + DERR_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int PUSH_W = DRIVE_W + 1;

    // pipeline depth from accept to result register
    localparam int PIPE_STAGES = 7;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 3'd0,
        CFG_KP     = 3'd1,
        CFG_KI     = 3'd2,
        CFG_KD     = 3'd3,
        CFG_LIMIT  = 3'd4,
        CFG_OFFSET = 3'd5
    } cfg_index_t;

    // register reset values
    localparam logic [POS_W-1:0]  TARGET_RST = 32'd0;
    localparam logic [GAIN_W-1:0] KP_RST     = 32'd5033165;
    localparam logic [GAIN_W-1:0] KI_RST     = 32'd34;
    localparam logic [GAIN_W-1:0] KD_RST     = 32'd83886080;
    localparam logic [LIM_W-1:0]  LIMIT_RST  = 15'd99;
    localparam logic [LIM_W-1:0]  OFFSET_RST = 15'd14;

    // drive code that the clamp can never produce
    localparam logic [DRIVE_W-1:0] DRIVE_FORBIDDEN = 16'h8000;

endpackage

`default_nettype wire

>>> rtl/pid_position_controller.sv
// an accepted word reaches out_valid through every stage register, given out_ready high
// throughput: one item per cycle while out_ready holds high, one result per item
// each stage moves on as soon as the stage after it is empty or moving
// reset clears all pipeline valids, last count, position, error sum and previous error,
// and loads the target, gain, limit and offset registers with their defaults
// ----------------------------------------------------------------------------
// pid position controller
// encoder count extension, pid step with saturating integrator, drive clamp
// and deadzone push, pipelined over seven registered stages
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_controller #(
    parameter int COUNTER_WIDTH  = pidpc_pkg::COUNTER_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pidpc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [pidpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [pidpc_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [COUNTER_WIDTH-1:0]               encoder_count,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [pidpc_pkg::DRIVE_W-1:0]        drive,
    output logic signed [pidpc_pkg::POS_W-1:0]          position,
    output logic signed [pidpc_pkg::POS_W-1:0]          error
);

    localparam int STAGES = pidpc_pkg::PIPE_STAGES;
    localparam int POS_W  = pidpc_pkg::POS_W;
    localparam int GAIN_W = pidpc_pkg::GAIN_W;
    localparam int LIM_W  = pidpc_pkg::LIM_W;
    localparam int DERR_W = pidpc_pkg::DERR_W;
    localparam int PROD_W = pidpc_pkg::PROD_W;
    localparam int ACC_W  = pidpc_pkg::ACC_W;
    localparam int PUSH_W = pidpc_pkg::PUSH_W;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        if (v > (POS_W+1)'(POS_MAX))
            return POS_MAX;
        else if (v < (POS_W+1)'(POS_MIN))
            return POS_MIN;
        else
            return POS_W'(v);
    endfunction

    // configuration registers
    logic signed [POS_W-1:0]  target_reg;
    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] ki_reg;
    logic signed [GAIN_W-1:0] kd_reg;
    logic [LIM_W-1:0]         limit_reg;
    logic [LIM_W-1:0]         offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= pidpc_pkg::TARGET_RST;
            kp_reg     <= pidpc_pkg::KP_RST;
            ki_reg     <= pidpc_pkg::KI_RST;
            kd_reg     <= pidpc_pkg::KD_RST;
            limit_reg  <= pidpc_pkg::LIMIT_RST;
            offset_reg <= pidpc_pkg::OFFSET_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pidpc_pkg::CFG_TARGET: target_reg <= cfg_data;
                pidpc_pkg::CFG_KP:     kp_reg     <= cfg_data;
                pidpc_pkg::CFG_KI:     ki_reg     <= cfg_data;
                pidpc_pkg::CFG_KD:     kd_reg     <= cfg_data;
                pidpc_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[LIM_W-1:0];
                pidpc_pkg::CFG_OFFSET: offset_reg <= cfg_data[LIM_W-1:0];
                default:               ;
            endcase
        end
    end

    // pipeline flow control: a stage loads when empty or when its word moves on
    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] load;

    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
            rdy[k] = !valid_reg[k] || rdy[k+1];
        load[0] = rdy[0] && in_valid;
        for (int k = 1; k < STAGES; k++)
            load[k] = rdy[k] && valid_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (rdy[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++)
                if (rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[STAGES-1];

    // stage 0: count difference
    logic [COUNTER_WIDTH-1:0] last_count_reg;
    logic [COUNTER_WIDTH-1:0] delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_count_reg <= '0;
        else if (load[0])
            last_count_reg <= encoder_count;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
            delta_reg <= encoder_count - last_count_reg;
    end

    // stage 1: extended position, wraps modulo 2^32
    logic signed [POS_W-1:0] pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (load[1])
            pos_reg <= pos_reg + POS_W'(signed'(delta_reg));
    end

    // stage 2: saturated error
    logic signed [POS_W-1:0] err2_reg;
    logic signed [POS_W-1:0] pos2_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            err2_reg <= sat_pos((POS_W+1)'(target_reg) - (POS_W+1)'(pos_reg));
            pos2_reg <= pos_reg;
        end
    end

    // stage 3: integrator and error difference
    logic signed [POS_W-1:0]  sum_reg;
    logic signed [POS_W-1:0]  prev_err_reg;
    logic signed [DERR_W-1:0] derr3_reg;
    logic signed [POS_W-1:0]  err3_reg;
    logic signed [POS_W-1:0]  pos3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            prev_err_reg <= '0;
        end
        else if (load[3])
        begin
            sum_reg      <= sat_pos((POS_W+1)'(sum_reg) + (POS_W+1)'(err2_reg));
            prev_err_reg <= err2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            derr3_reg <= DERR_W'(err2_reg) - DERR_W'(prev_err_reg);
            err3_reg  <= err2_reg;
            pos3_reg  <= pos2_reg;
        end
    end

    // stage 4: gain products
    logic signed [PROD_W-1:0] p_kp_reg;
    logic signed [PROD_W-1:0] p_ki_reg;
    logic signed [PROD_W-1:0] p_kd_reg;
    logic signed [POS_W-1:0]  err4_reg;
    logic signed [POS_W-1:0]  pos4_reg;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            p_kp_reg <= PROD_W'(kp_reg) * PROD_W'(err3_reg);
            p_ki_reg <= PROD_W'(ki_reg) * PROD_W'(sum_reg);
            p_kd_reg <= PROD_W'(kd_reg) * PROD_W'(derr3_reg);
            err4_reg <= err3_reg;
            pos4_reg <= pos3_reg;
        end
    end

    // stage 5: exact sum of the products
    logic signed [ACC_W-1:0] acc5_reg;
    logic signed [POS_W-1:0] err5_reg;
    logic signed [POS_W-1:0] pos5_reg;

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            acc5_reg <= ACC_W'(p_kp_reg) + ACC_W'(p_ki_reg) + ACC_W'(p_kd_reg);
            err5_reg <= err4_reg;
            pos5_reg <= pos4_reg;
        end
    end

    // stage 6: floor shift, clamp, deadzone push, clamp again
    logic signed [ACC_W-1:0]  acc_sh;
    logic signed [ACC_W-1:0]  lim_wide;
    logic signed [PUSH_W-1:0] lim_n;
    logic signed [PUSH_W-1:0] off_n;
    logic signed [PUSH_W-1:0] clamped;
    logic signed [PUSH_W-1:0] pushed;
    logic signed [PUSH_W-1:0] drive_next;

    assign acc_sh   = acc5_reg >>> GAIN_FRAC_BITS;
    assign lim_wide = ACC_W'(signed'({1'b0, limit_reg}));
    assign lim_n    = PUSH_W'(signed'({1'b0, limit_reg}));
    assign off_n    = PUSH_W'(signed'({1'b0, offset_reg}));

    always_comb
    begin
        if (acc_sh > lim_wide)
            clamped = lim_n;
        else if (acc_sh < -lim_wide)
            clamped = -lim_n;
        else
            clamped = PUSH_W'(acc_sh);

        // zero drive stays zero
        if (clamped > 0)
        begin
            pushed     = clamped + off_n;
            drive_next = (pushed > lim_n) ? lim_n : pushed;
        end
        else if (clamped < 0)
        begin
            pushed     = clamped - off_n;
            drive_next = (pushed < -lim_n) ? -lim_n : pushed;
        end
        else
        begin
            pushed     = '0;
            drive_next = '0;
        end
    end

    logic signed [pidpc_pkg::DRIVE_W-1:0] drive_reg;
    logic signed [POS_W-1:0]              error_reg;
    logic signed [POS_W-1:0]              position_reg;

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            drive_reg    <= pidpc_pkg::DRIVE_W'(drive_next);
            error_reg    <= err5_reg;
            position_reg <= pos5_reg;
        end
    end

    assign drive    = drive_reg;
    assign position = position_reg;
    assign error    = error_reg;

endmodule

`default_nettype wire

>>> rtl/pidpc_checker.sv
// ----------------------------------------------------------------------------
// pid position controller port checker
// watches the channels for held results, invented results and occupancy
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_position_controller_defines.svh"

module pidpc_port_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic [pidpc_pkg::DRIVE_W-1:0]       drive,
    input wire logic [pidpc_pkg::POS_W-1:0]         position,
    input wire logic [pidpc_pkg::POS_W-1:0]         error
);

    localparam int CNT_W = $clog2(pidpc_pkg::PIPE_STAGES + 1);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // words accepted but not yet delivered
    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
            count_next = count_reg + 1'b1;
        else if (!in_acc && out_acc)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    `PIDPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(drive) && $stable(position) && $stable(error),
        "stalled result changed")
    `PIDPC_ASSERT_IMP(a_no_extra, out_valid, count_reg != '0,
        "result without accepted word")
    `PIDPC_ASSERT(a_depth, count_reg <= CNT_W'(pidpc_pkg::PIPE_STAGES),
        "more words in flight than stages")
    `PIDPC_ASSERT_IMP(a_drive_range, out_valid, drive != pidpc_pkg::DRIVE_FORBIDDEN,
        "drive outside symmetric range")

endmodule

bind pid_position_controller pidpc_port_checker u_pidpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .position  (position),
    .error     (error)
);

`default_nettype wire

>>> test/pidpc_checker.sv
// ----------------------------------------------------------------------------
// pid position controller result checker
// follows every accepted count word through its own pid step and compares
// drive, position and error with each result word, oldest first
// ----------------------------------------------------------------------------
module pidpc_checker
    import pidpc_pkg::*;
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [CFG_IDX_W-1:0]                cfg_index,
    input  wire logic [CFG_W-1:0]                    cfg_data,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic [COUNTER_WIDTH_DEF-1:0]        encoder_count,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic signed [DRIVE_W-1:0]           drive,
    input  wire logic signed [POS_W-1:0]             position,
    input  wire logic signed [POS_W-1:0]             error,
    output int                                       mismatches,
    output int                                       ticks_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = GAIN_FRAC_BITS_DEF;
    localparam int WIDE_W     = 67;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   error;
    } pid_tick_t;

    // register copies
    logic signed [31:0] target;
    logic signed [31:0] kp_gain;
    logic signed [31:0] ki_gain;
    logic signed [31:0] kd_gain;
    logic [LIM_W-1:0]   drive_lim;
    logic [LIM_W-1:0]   push_off;

    // controller state
    logic [15:0]        last_cnt;
    logic [31:0]        pos_acc;
    logic signed [31:0] prev_err;
    logic signed [31:0] err_sum;

    pid_tick_t predicted_ticks[$];
    pid_tick_t want;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [WIDE_W-1:0] clamp_drive(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [WIDE_W-1:0] lim
    );
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // one control tick: extend the count, pid sum, clamp, deadzone push
    function automatic pid_tick_t pid_step(input logic [15:0] count);
        logic [15:0]               delta;
        logic signed [31:0]        pos;
        logic signed [31:0]        err;
        logic signed [32:0]        wide;
        logic signed [32:0]        derr;
        logic signed [WIDE_W-1:0]  acc;
        logic signed [WIDE_W-1:0]  u;
        logic signed [WIDE_W-1:0]  lim;
        logic signed [WIDE_W-1:0]  off;
        pid_tick_t                 r;
        delta    = count - last_cnt;
        pos_acc  = pos_acc + {{16{delta[15]}}, delta};
        last_cnt = count;
        pos      = pos_acc;
        wide     = target - pos;
        err      = sat32(wide);
        wide     = err_sum + err;
        err_sum  = sat32(wide);
        derr     = err - prev_err;
        prev_err = err;
        // exact sum of the three products, floored by the arithmetic shift
        acc = kp_gain * err + ki_gain * err_sum + kd_gain * derr;
        u   = acc >>> FRAC;
        lim = $signed({52'd0, drive_lim});
        off = $signed({52'd0, push_off});
        u   = clamp_drive(u, lim);
        if (u > 0)
            u = clamp_drive(u + off, lim);
        else if (u < 0)
            u = clamp_drive(u - off, lim);
        r.drive    = u[DRIVE_W-1:0];
        r.position = pos;
        r.error    = err;
        return r;
    endfunction

    function automatic void check_field(
        input string              name,
        input logic signed [31:0] exp_val,
        input logic signed [31:0] got_val
    );
        if (got_val !== exp_val)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target    = TARGET_RST;
            kp_gain   = KP_RST;
            ki_gain   = KI_RST;
            kd_gain   = KD_RST;
            drive_lim = LIMIT_RST;
            push_off  = OFFSET_RST;
            last_cnt  = '0;
            pos_acc   = '0;
            prev_err  = '0;
            err_sum   = '0;
            predicted_ticks.delete();
            ticks_in_flight = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_ticks.size() == 0)
                begin
                    mismatches++;
                    $error("result word with no prediction waiting");
                end
                else
                begin
                    want = predicted_ticks.pop_front();
                    check_field("drive", $signed(want.drive), drive);
                    check_field("position", $signed(want.position), position);
                    check_field("error", $signed(want.error), error);
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TARGET: target    = cfg_data;
                    CFG_KP:     kp_gain   = cfg_data;
                    CFG_KI:     ki_gain   = cfg_data;
                    CFG_KD:     kd_gain   = cfg_data;
                    CFG_LIMIT:  drive_lim = cfg_data[LIM_W-1:0];
                    CFG_OFFSET: push_off  = cfg_data[LIM_W-1:0];
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
                predicted_ticks.push_back(pid_step(encoder_count));
            ticks_in_flight = predicted_ticks.size();
        end
    end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// pid position controller testbench
// drives count words and register writes with random gaps on both channels:
// a short sweep of half-range count steps, short edge-value phases, then
// random gain settings over random-walk and noisy count streams
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pidpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SWEEP_ITEMS    = 16;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 152;
    localparam int SETTLE         = 2 * PIPE_STAGES;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [15:0] EXTREME_COUNTS [8] = '{
        16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF,
        16'h8000, 16'h0001, 16'h5555, 16'hAAAA
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]              cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [COUNTER_WIDTH_DEF-1:0]  encoder_count = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [DRIVE_W-1:0]     drive;
    logic signed [POS_W-1:0]       position;
    logic signed [POS_W-1:0]       error;

    int                 mismatches;
    int                 ticks_in_flight;
    bit                 steady = 1'b0;
    bit                 timed_out = 1'b0;
    logic signed [31:0] seen_pos = '0;
    logic [15:0]        last_sent = '0;

    pid_position_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .encoder_count (encoder_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive         (drive),
        .position      (position),
        .error         (error)
    );

    pidpc_checker tick_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .encoder_count   (encoder_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .drive           (drive),
        .position        (position),
        .error           (error),
        .mismatches      (mismatches),
        .ticks_in_flight (ticks_in_flight)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        return steady ? 0 : int'($urandom_range(0, 3));
    endfunction

    // mostly modest gains in either sign, now and then any 32-bit pattern
    function automatic logic [31:0] pick_gain(input int mag_bits);
        logic [31:0] v;
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        v = $urandom_range(0, 1 << mag_bits);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [LIM_W-1:0] pick_bound(input int spread);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 15'h7FFF;
            default: return LIM_W'($urandom_range(0, spread));
        endcase
    endfunction

    task automatic send_count(input logic [15:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        encoder_count <= c;
        last_sent = c;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    // wait until every result word is back, leaving the block idle
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (ticks_in_flight != 0);
        @(posedge clk);
    endtask

    // unused upper data bits on the narrow registers carry random junk
    task automatic program_regs(
        input logic [31:0]      tgt,
        input logic [31:0]      kp,
        input logic [31:0]      ki,
        input logic [31:0]      kd,
        input logic [LIM_W-1:0] lim,
        input logic [LIM_W-1:0] off
    );
        write_reg(CFG_SPARE_LO, $urandom());
        write_reg(CFG_TARGET, tgt);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_LIMIT, {17'($urandom()), lim});
        write_reg(CFG_OFFSET, {17'($urandom()), off});
        write_reg(CFG_SPARE_HI, $urandom());
        cfg_write <= 1'b0;
    endtask

    // result side: random stall before each word
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            seen_pos = position;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin : stimulus
                logic [31:0] tgt;
                logic [15:0] step;

                // steps of -32768, the largest the counter allows, drive the
                // position away from the target back to back
                steady = 1'b1;
                for (int i = 0; i < SWEEP_ITEMS; i++)
                    send_count(i[0] ? 16'h0000 : 16'h8000);
                steady = 1'b0;

                // error and integrator saturate against the far target
                drain_results();
                program_regs(S32_MAX, S32_MIN, S32_MAX, S32_MIN, 15'h7FFF, 15'h7FFF);
                for (int k = 0; k < 8; k++)
                    send_count(EXTREME_COUNTS[k]);

                // zero drive limit
                drain_results();
                program_regs(S32_MIN, S32_MAX, S32_MIN, S32_MAX, 15'd0, 15'h7FFF);
                send_count(16'h1234);
                send_count(16'h0000);
                send_count(16'hFFFF);
                send_count(16'h8000);

                // all gains zero, drive must stay at zero with no offset
                drain_results();
                program_regs('0, '0, '0, '0, 15'h7FFF, 15'd0);
                send_count(last_sent + 16'd1);
                send_count(last_sent + 16'h4000);
                send_count(last_sent - 16'd3);

                // half gain on small errors, fractions floored both ways
                drain_results();
                program_regs(seen_pos, 32'h0080_0000, '0, '0, 15'd20, 15'd3);
                send_count(last_sent + 16'd1);
                send_count(last_sent + 16'd2);
                send_count(last_sent + 16'd3);
                send_count(last_sent - 16'd7);
                send_count(last_sent - 16'd40);

                // offset pushes every nonzero drive onto the limit
                drain_results();
                program_regs(seen_pos + 3, 32'h0100_0000, '0, '0, 15'd5, 15'h7FFF);
                send_count(last_sent);
                send_count(last_sent + 16'd1);
                send_count(last_sent + 16'd5);

                for (int ph = 0; ph < RANDOM_PHASES; ph++)
                begin
                    drain_results();
                    steady = (ph % 3 == 2);
                    if ($urandom_range(0, 4) == 0)
                        tgt = $urandom();
                    else
                        tgt = seen_pos + $urandom_range(0, 4000) - 2000;
                    program_regs(tgt, pick_gain(25), pick_gain(18), pick_gain(26),
                                 pick_bound(32767), pick_bound(200));
                    for (int n = 0; n < PHASE_ITEMS; n++)
                    begin
                        // mostly a slow random walk, some raw noise words
                        if ($urandom_range(0, 9) < 2)
                            step = 16'($urandom());
                        else
                            step = last_sent + 16'($urandom_range(0, 256) - 128);
                        send_count(step);
                    end
                end

                drain_results();
                repeat (SETTLE) @(posedge clk);
            end
            begin : watchdog
                int idle;
                idle = 0;
                while (idle < WATCHDOG_LIMIT)
                begin
                    @(posedge clk);
                    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                        idle = 0;
                    else
                        idle++;
                end
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && mismatches == 0)
            $display("PASS pid_position_controller");
        else
            $display("FAIL pid_position_controller");
        $finish;
    end

endmodule
